[rtl/core/command_line_tokenizer_macros.svh]
// ----------------------------------------------------------------------------
// Command line tokenizer assertion macros
// Clocked, reset-gated property checks shared by the tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef COMMAND_LINE_TOKENIZER_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CLT_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define CLT_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define CLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define CLT_ASSERT(label, expr, msg)

`define CLT_ASSERT_IMPLY(label, ante, cons, msg)

`define CLT_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[rtl/core/clt_pkg.sv]
// ----------------------------------------------------------------------------
// Command line tokenizer package
// Beat types, character codes, scan modes and escape decoding.
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_BEL       = 8'h07;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_B   = 8'h62;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;

  typedef enum logic [1:0] {
    MODE_GAP    = 2'd0,
    MODE_BARE   = 2'd1,
    MODE_QUOTED = 2'd2,
    MODE_ESCAPE = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } tok_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       token_end;
    logic       command_end;
    logic       command_word;
  } tok_out_t;

  function automatic logic [7:0] decode_escape(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      CH_LOWER_N: r = CH_LF;
      CH_LOWER_R: r = CH_CR;
      CH_LOWER_T: r = CH_TAB;
      CH_LOWER_B: r = CH_BS;
      CH_LOWER_A: r = CH_BEL;
      default:    r = b;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/command_line_tokenizer.sv]
// ----------------------------------------------------------------------------
// Command line tokenizer
// Output: a result beat is registered and appears in the cycle after the byte that causes it.
// Throughput: one byte per cycle; the scan state and the output register
// update in the same cycle, so the input stalls only while a held result
// beat is not taken.
// Reset: synchronous; scan state returns to between tokens, no open command.
// ----------------------------------------------------------------------------
`include "command_line_tokenizer_macros.svh"

module command_line_tokenizer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  clt_pkg::tok_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output clt_pkg::tok_out_t out_data
);

  import clt_pkg::*;

  mode_t    mode;
  mode_t    mode_next;
  logic     command_open;
  logic     command_open_next;
  logic     in_command_word;
  logic     in_command_word_next;
  logic     in_fire;
  logic     emit;
  tok_out_t result;
  logic     ws;
  logic     nl;
  logic     cend;
  logic     is_quote;
  logic     is_bslash;
  logic     last;
  logic [7:0] b;

  assign b         = in_data.in_byte;
  assign last      = in_data.in_last;
  assign nl        = (b == CH_LF);
  assign ws        = b inside {CH_LF, CH_SPACE, CH_TAB, CH_CR};
  assign cend      = nl || last;
  assign is_quote  = (b == CH_QUOTE);
  assign is_bslash = (b == CH_BACKSLASH);

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    mode_next            = mode;
    command_open_next    = command_open;
    in_command_word_next = in_command_word;
    case (mode)
      MODE_GAP: begin
        if (ws) begin
          if (cend) begin
            command_open_next    = 1'b0;
            in_command_word_next = 1'b0;
          end
        end else begin
          in_command_word_next = !command_open;
          command_open_next    = 1'b1;
          mode_next            = is_quote ? MODE_QUOTED : MODE_BARE;
        end
      end
      MODE_BARE: begin
        if (ws) begin
          mode_next = MODE_GAP;
          if (cend) begin
            command_open_next = 1'b0;
          end
        end
      end
      MODE_QUOTED: begin
        if (is_quote) begin
          mode_next = MODE_GAP;
        end else if (is_bslash && !last) begin
          mode_next = MODE_ESCAPE;
        end
      end
      MODE_ESCAPE: begin
        mode_next = MODE_QUOTED;
      end
      default: begin
        mode_next = MODE_GAP;
      end
    endcase
    if (last) begin
      mode_next            = MODE_GAP;
      command_open_next    = 1'b0;
      in_command_word_next = 1'b0;
    end
  end

  always_comb begin
    emit   = 1'b0;
    result = '0;
    case (mode)
      MODE_GAP: begin
        if (ws) begin
          emit               = cend && command_open;
          result.command_end = 1'b1;
        end else if (is_quote) begin
          emit                = last;
          result.token_end    = 1'b1;
          result.command_end  = 1'b1;
          result.command_word = !command_open;
        end else begin
          emit                = 1'b1;
          result.out_byte     = b;
          result.has_byte     = 1'b1;
          result.token_end    = last;
          result.command_end  = last;
          result.command_word = !command_open;
        end
      end
      MODE_BARE: begin
        emit                = 1'b1;
        result.command_word = in_command_word;
        if (ws) begin
          result.token_end   = 1'b1;
          result.command_end = cend;
        end else begin
          result.out_byte    = b;
          result.has_byte    = 1'b1;
          result.token_end   = last;
          result.command_end = last;
        end
      end
      MODE_QUOTED: begin
        result.command_word = in_command_word;
        if (is_quote) begin
          emit               = 1'b1;
          result.token_end   = 1'b1;
          result.command_end = last;
        end else if (!(is_bslash && !last)) begin
          emit               = 1'b1;
          result.out_byte    = b;
          result.has_byte    = 1'b1;
          result.token_end   = last;
          result.command_end = last;
        end
      end
      MODE_ESCAPE: begin
        emit                = 1'b1;
        result.out_byte     = decode_escape(b);
        result.has_byte     = 1'b1;
        result.token_end    = last;
        result.command_end  = last;
        result.command_word = in_command_word;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_GAP;
      command_open    <= 1'b0;
      in_command_word <= 1'b0;
    end else if (in_fire) begin
      mode            <= mode_next;
      command_open    <= command_open_next;
      in_command_word <= in_command_word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_data <= result;
    end
  end

  `CLT_ASSERT_IMPLY(a_no_byte_zero, out_valid && !out_data.has_byte, out_data.out_byte == 8'h00, "out_byte nonzero without has_byte")
  `CLT_ASSERT_IMPLY(a_cw_needs_token, out_valid && out_data.command_word, out_data.has_byte || out_data.token_end, "command_word on a command-end-only beat")
  `CLT_ASSERT_IMPLY(a_escape_open, mode == MODE_ESCAPE, command_open, "escape pending outside an open command")
  `CLT_ASSERT_NEXT(a_last_clears, in_fire && in_data.in_last, mode == MODE_GAP && !command_open && !in_command_word, "state not cleared after final byte")

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Command line tokenizer testbench
// Walks a table of directed text bytes and expected beats, then streams
// random command lines (bare words, quoted strings with escapes, separators,
// newlines, noise and broken quotes) through the tokenizer under three mixes
// of sender and receiver stalls. Each result beat is checked field by field
// against the table's expected beat or an in-bench tokenizer model.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import clt_pkg::*;

  typedef struct {
    tok_in_t  stim;
    bit       typed;
    bit       want;
    tok_out_t beat;
  } row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  tok_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  tok_out_t out_data;

  tok_out_t beats_due[$];
  tok_in_t  text_q[$];
  row_t     rows[$];
  int       mismatches = 0;
  int       tx_idle_pct = 0;
  int       rx_idle_pct = 0;

  mode_t    mode = MODE_GAP;
  bit       cmd_open = 1'b0;
  bit       cmd_word = 1'b0;

  command_line_tokenizer dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void tokenize_byte(input tok_in_t b, output bit produced,
                                        output tok_out_t beat);
    logic [7:0] c;
    logic [7:0] d;
    bit         nl;
    bit         ws;
    bit         cend;
    c = b.in_byte;
    nl = (c == CH_LF);
    ws = nl || c == CH_SPACE || c == CH_TAB || c == CH_CR;
    cend = nl || b.in_last;
    produced = 1'b0;
    beat = '0;
    case (mode)
      MODE_GAP: begin
        if (ws) begin
          if (cend && cmd_open) begin
            produced = 1'b1;
            beat.command_end = 1'b1;
          end
          if (cend) begin
            cmd_open = 1'b0;
            cmd_word = 1'b0;
          end
        end else begin
          cmd_word = !cmd_open;
          cmd_open = 1'b1;
          if (c == CH_QUOTE) begin
            mode = MODE_QUOTED;
            if (b.in_last) begin
              produced = 1'b1;
              beat = '{8'h00, 1'b0, 1'b1, 1'b1, cmd_word};
            end
          end else begin
            mode = MODE_BARE;
            produced = 1'b1;
            beat = '{c, 1'b1, b.in_last, b.in_last, cmd_word};
          end
        end
      end
      MODE_BARE: begin
        produced = 1'b1;
        if (ws) begin
          beat = '{8'h00, 1'b0, 1'b1, cend, cmd_word};
          mode = MODE_GAP;
          if (cend) cmd_open = 1'b0;
        end else begin
          beat = '{c, 1'b1, b.in_last, b.in_last, cmd_word};
        end
      end
      MODE_QUOTED: begin
        if (c == CH_QUOTE) begin
          produced = 1'b1;
          beat = '{8'h00, 1'b0, 1'b1, b.in_last, cmd_word};
          mode = MODE_GAP;
        end else if (c == CH_BACKSLASH && !b.in_last) begin
          mode = MODE_ESCAPE;
        end else begin
          produced = 1'b1;
          beat = '{c, 1'b1, b.in_last, b.in_last, cmd_word};
        end
      end
      default: begin
        case (c)
          CH_LOWER_N: d = CH_LF;
          CH_LOWER_R: d = CH_CR;
          CH_LOWER_T: d = CH_TAB;
          CH_LOWER_B: d = CH_BS;
          CH_LOWER_A: d = CH_BEL;
          default:    d = c;
        endcase
        produced = 1'b1;
        beat = '{d, 1'b1, b.in_last, b.in_last, cmd_word};
        mode = MODE_QUOTED;
      end
    endcase
    if (b.in_last) begin
      mode = MODE_GAP;
      cmd_open = 1'b0;
      cmd_word = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, field, got, want);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    tok_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (beats_due.size() == 0) begin
        report_mismatch("unexpected beat", out_data, 0);
      end else begin
        want = beats_due.pop_front();
        if (out_data.out_byte !== want.out_byte)
          report_mismatch("out_byte", out_data.out_byte, want.out_byte);
        if (out_data.has_byte !== want.has_byte)
          report_mismatch("has_byte", out_data.has_byte, want.has_byte);
        if (out_data.token_end !== want.token_end)
          report_mismatch("token_end", out_data.token_end, want.token_end);
        if (out_data.command_end !== want.command_end)
          report_mismatch("command_end", out_data.command_end, want.command_end);
        if (out_data.command_word !== want.command_word)
          report_mismatch("command_word", out_data.command_word, want.command_word);
      end
    end
  end

  task automatic send_text(input tok_in_t d, input bit typed, input bit want,
                           input tok_out_t want_beat);
    bit       produced;
    tok_out_t beat;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
    tokenize_byte(d, produced, beat);
    if (typed) begin
      produced = want;
      beat = want_beat;
    end
    if (produced) beats_due.insert(beats_due.size(), beat);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_row(input logic [7:0] c, input bit last, input bit typed,
                         input bit want, input tok_out_t beat);
    row_t r;
    r.stim = '{c, last};
    r.typed = typed;
    r.want = want;
    r.beat = beat;
    rows.insert(rows.size(), r);
  endtask

  task automatic push_byte(input logic [7:0] c, input bit last);
    text_q.insert(text_q.size(), '{c, last});
  endtask

  function automatic logic [7:0] pick_sep();
    case ($urandom_range(0, 2))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] pick_escape();
    case ($urandom_range(0, 5))
      0:       return CH_LOWER_N;
      1:       return CH_LOWER_R;
      2:       return CH_LOWER_T;
      3:       return CH_LOWER_B;
      4:       return CH_LOWER_A;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic plan_text();
    int         kind;
    int         ntok;
    int         len;
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      if ($urandom_range(0, 4) == 0) push_byte(pick_sep(), 1'b0);
      ntok = $urandom_range(1, 4);
      for (int t = 0; t < ntok; t++) begin
        if (t > 0) repeat ($urandom_range(1, 2)) push_byte(pick_sep(), 1'b0);
        if ($urandom_range(0, 9) < 6) begin
          len = $urandom_range(1, 6);
          repeat (len) push_byte(8'($urandom_range(8'h21, 8'hFF)), 1'b0);
        end else begin
          push_byte(CH_QUOTE, 1'b0);
          len = $urandom_range(0, 6);
          repeat (len) begin
            if ($urandom_range(0, 9) < 3) begin
              push_byte(CH_BACKSLASH, 1'b0);
              push_byte(pick_escape(), 1'b0);
            end else begin
              c = 8'($urandom);
              if (c == CH_QUOTE || c == CH_BACKSLASH) c = CH_LOWER_A;
              push_byte(c, 1'b0);
            end
          end
          if ($urandom_range(0, 9) != 0) push_byte(CH_QUOTE, 1'b0);
        end
      end
      if ($urandom_range(0, 6) == 0) text_q[text_q.size() - 1].in_last = 1'b1;
      else push_byte(CH_LF, 1'b0);
    end else if (kind < 90) begin
      repeat ($urandom_range(1, 8)) push_byte(8'($urandom), $urandom_range(0, 15) == 0);
    end else begin
      push_byte(CH_QUOTE, 1'b0);
      repeat ($urandom_range(0, 3)) push_byte(8'($urandom), 1'b0);
      if ($urandom_range(0, 1) == 0) push_byte(CH_BACKSLASH, 1'b1);
      else push_byte(8'($urandom), 1'b1);
    end
  endtask

  initial begin
    int targets[3] = '{400, 400, 400};
    int tx_pct[3]  = '{11, 70, 0};
    int rx_pct[3]  = '{70, 11, 0};
    int sent;

    add_row(8'h6C, 1'b0, 1'b1, 1'b1, '{8'h6C, 1'b1, 1'b0, 1'b0, 1'b1});
    add_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
    add_row(CH_SPACE, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1});
    add_row(CH_QUOTE, 1'b0, 1'b0, 1'b0, '0);
    add_row(CH_TAB, 1'b0, 1'b0, 1'b0, '0);
    add_row(CH_BACKSLASH, 1'b0, 1'b0, 1'b0, '0);
    add_row(CH_LOWER_N, 1'b0, 1'b0, 1'b0, '0);
    add_row(CH_BACKSLASH, 1'b0, 1'b0, 1'b0, '0);
    add_row(CH_QUOTE, 1'b0, 1'b0, 1'b0, '0);
    add_row(CH_QUOTE, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0});
    add_row(CH_LF, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0});
    add_row(CH_LF, 1'b0, 1'b1, 1'b0, '0);
    add_row(CH_QUOTE, 1'b0, 1'b0, 1'b0, '0);
    add_row(CH_QUOTE, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1});
    add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(CH_QUOTE, 1'b0, 1'b0, 1'b0, '0);
    add_row(CH_CR, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h71, 1'b0, 1'b0, 1'b0, '0);
    add_row(CH_LF, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0});
    add_row(CH_QUOTE, 1'b0, 1'b0, 1'b0, '0);
    add_row(CH_BACKSLASH, 1'b1, 1'b1, 1'b1, '{CH_BACKSLASH, 1'b1, 1'b1, 1'b1, 1'b1});
    add_row(CH_QUOTE, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1});
    add_row(CH_SPACE, 1'b1, 1'b1, 1'b0, '0);
    add_row(8'h7A, 1'b0, 1'b0, 1'b0, '0);
    add_row(CH_TAB, 1'b1, 1'b0, 1'b0, '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = tx_pct[0];
    rx_idle_pct = rx_pct[0];
    foreach (rows[i]) send_text(rows[i].stim, rows[i].typed, rows[i].want, rows[i].beat);
    drain();

    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = tx_pct[p];
      rx_idle_pct = rx_pct[p];
      sent = 0;
      while (sent < targets[p]) begin
        if (text_q.size() == 0) plan_text();
        send_text(text_q.pop_front(), 1'b0, 1'b0, '0);
        sent++;
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[command_line_tokenizer.f]
+incdir+rtl/core
rtl/core/clt_pkg.sv
rtl/core/command_line_tokenizer.sv
tb/tb.sv
